[sv/postfix_expression_evaluator_macros.svh]
// assertion macros shared by the checker
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PFX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PFX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pfx_pkg.sv]
package pfx_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 8;

  // default stack depth
  localparam int STACK_DEPTH_DEF = 128;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_TIMES = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_MOD   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

  // error codes
  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  // keep only the first error
  function automatic err_t note_error(err_t cur, err_t code);
    note_error = (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

[sv/postfix_expression_evaluator.sv]
// channel   direction  ports                                   handshake
// in        input      in_character                            in_valid / in_ready
// out       output     out_value, out_status, out_leftover     out_valid / out_ready
//
// one request at a time: an operand passes idle and pop_b; '+' '-' '*' add wait_a,
// pop_a and push, parentheses end at pop_a, '/' and '%' wait 32 steps of the shared divider
// a space passes pop_b and emit, plus any wait for the output register to free
// the stack is a single-port-write memory read through a registered top port
// synchronous active-low reset clears count, error and handshake state
// the stack contents are not cleared; only entries below the count are read

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pfx_pkg::CHAR_W-1:0]          in_character,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfx_pkg::DATA_W-1:0]   out_value,
  output logic [pfx_pkg::STATUS_W-1:0]        out_status,
  output logic [pfx_pkg::LEFT_W-1:0]          out_leftover
);

  localparam int DW = pfx_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_WAIT_A,
    S_POP_A,
    S_DIV,
    S_PUSH,
    S_EMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pfx_pkg::CHAR_W-1:0]   ch_r, ch_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  pfx_pkg::err_t                err_r, err_nxt;
  logic [DW-1:0]                b_r, b_nxt;
  logic [DW-1:0]                res_r, res_nxt;
  logic [DW-1:0]                val_r, val_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [DW-1:0]                out_value_r, out_value_nxt;
  logic [pfx_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pfx_pkg::LEFT_W-1:0]   out_left_r, out_left_nxt;

  logic [DW-1:0]                mem [STACK_DEPTH];
  logic [DW-1:0]                rd_data_r;
  logic [CW-1:0]                cnt_dec;
  logic [AW-1:0]                top_idx;
  logic [AW-1:0]                wr_addr;
  logic                         wr_en;
  logic [DW-1:0]                wr_data;

  logic                         is_op;
  logic                         is_empty;
  logic                         is_full;
  logic [DW-1:0]                a_val;
  logic [DW-1:0]                operand;

  pfx_pkg::div_req_t            div_req;
  pfx_pkg::div_rsp_t            div_rsp;

  // stack memory, top entry read every cycle
  assign cnt_dec = cnt_r - CW'(1);
  assign top_idx = cnt_dec[AW-1:0];
  assign wr_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[top_idx];
  end

  // shared divider
  pfx_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // decode
  assign is_op    = (ch_r inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_TIMES,
                                  pfx_pkg::CH_DIV, pfx_pkg::CH_MOD, pfx_pkg::CH_LPAR,
                                  pfx_pkg::CH_RPAR});
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r >= CNT_FULL);
  assign a_val    = is_empty ? '0 : rd_data_r;
  assign operand  = {{(DW - pfx_pkg::CHAR_W){1'b0}}, ch_r} -
                    {{(DW - pfx_pkg::CHAR_W){1'b0}}, pfx_pkg::CH_ZERO};

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    b_nxt          = b_r;
    res_nxt        = res_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_left_nxt   = out_left_r;
    wr_en          = 1'b0;
    wr_data        = res_r;
    div_req.start    = 1'b0;
    div_req.dividend = a_val;
    div_req.divisor  = b_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_character;
          state_nxt = S_POP_B;
        end
      end
      S_POP_B: begin
        if (ch_r == pfx_pkg::CH_SPACE || is_op) begin
          // pop the right operand or the final value
          if (is_empty) begin
            b_nxt   = '0;
            val_nxt = '0;
            err_nxt = pfx_pkg::note_error(err_r, pfx_pkg::ERR_EMPTY);
          end else begin
            b_nxt   = rd_data_r;
            val_nxt = rd_data_r;
            cnt_nxt = cnt_dec;
          end
          state_nxt = (ch_r == pfx_pkg::CH_SPACE) ? S_EMIT : S_WAIT_A;
        end else begin
          // operand byte
          if (is_full) begin
            err_nxt = pfx_pkg::note_error(err_r, pfx_pkg::ERR_FULL);
          end else begin
            wr_en   = 1'b1;
            wr_data = operand;
            cnt_nxt = cnt_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_WAIT_A: begin
        // new top read after the pop
        state_nxt = S_POP_A;
      end
      S_POP_A: begin
        if (is_empty) begin
          err_nxt = pfx_pkg::note_error(err_r, pfx_pkg::ERR_EMPTY);
        end else begin
          cnt_nxt = cnt_dec;
        end
        case (ch_r)
          pfx_pkg::CH_PLUS: begin
            res_nxt   = a_val + b_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_MINUS: begin
            res_nxt   = a_val - b_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_TIMES: begin
            res_nxt   = a_val * b_r;
            state_nxt = S_PUSH;
          end
          pfx_pkg::CH_DIV, pfx_pkg::CH_MOD: begin
            if (b_r == '0) begin
              res_nxt   = '0;
              err_nxt   = pfx_pkg::note_error(is_empty ?
                            pfx_pkg::note_error(err_r, pfx_pkg::ERR_EMPTY) : err_r,
                            pfx_pkg::ERR_DIV0);
              state_nxt = S_PUSH;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            // parentheses push nothing
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = (ch_r == pfx_pkg::CH_DIV) ? div_rsp.quot : div_rsp.rem;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (is_full) begin
          err_nxt = pfx_pkg::note_error(err_r, pfx_pkg::ERR_FULL);
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // wait for the output register, then clear the stack
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = val_r;
          out_status_nxt = err_r;
          out_left_nxt   = pfx_pkg::LEFT_W'(cnt_r);
          cnt_nxt        = '0;
          err_nxt        = pfx_pkg::ERR_NONE;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= pfx_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r         <= ch_nxt;
    b_r          <= b_nxt;
    res_r        <= res_nxt;
    val_r        <= val_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_left_r   <= out_left_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;
  assign out_leftover = out_left_r;

endmodule

[sv/pfx_divider.sv]
module pfx_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  pfx_pkg::div_req_t req,
  output pfx_pkg::div_rsp_t rsp
);

  localparam int DW     = pfx_pkg::DATA_W;
  localparam int STEP_W = $clog2(DW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DW - 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t           state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DW-1:0]     q_r, q_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic              done_r, done_nxt;
  logic [DW-1:0]     quot_r, quot_nxt;
  logic [DW-1:0]     remo_r, remo_nxt;

  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              ge;

  // one restoring step per cycle on the magnitudes
  assign shifted = {rem_r, q_r[DW-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    done_nxt  = 1'b0;
    quot_nxt  = quot_r;
    remo_nxt  = remo_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          q_nxt     = req.dividend[DW-1] ? (~req.dividend + 1'b1) : req.dividend;
          dvs_nxt   = req.divisor[DW-1] ? (~req.divisor + 1'b1) : req.divisor;
          rem_nxt   = '0;
          neg_q_nxt = req.dividend[DW-1] ^ req.divisor[DW-1];
          neg_r_nxt = req.dividend[DW-1];
          step_nxt  = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt  = ge ? diff[DW-1:0] : shifted[DW-1:0];
        q_nxt    = {q_r[DW-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = D_FIX;
        end
      end
      D_FIX: begin
        // signs follow c truncation: remainder takes the dividend's sign
        quot_nxt  = neg_q_r ? (~q_r + 1'b1) : q_r;
        remo_nxt  = neg_r_r ? (~rem_r + 1'b1) : rem_r;
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    step_r  <= step_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    quot_r  <= quot_nxt;
    remo_r  <= remo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = remo_r;

endmodule

[sv/pfx_checker.sv]
`include "postfix_expression_evaluator_macros.svh"

module pfx_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [pfx_pkg::CHAR_W-1:0]        in_character,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pfx_pkg::DATA_W-1:0] out_value,
  input logic [pfx_pkg::STATUS_W-1:0]      out_status,
  input logic [pfx_pkg::LEFT_W-1:0]        out_leftover
);

  // a stalled result holds
  `PFX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_value) && $stable(out_status) && $stable(out_leftover),
    "stalled result changed")

  // every request makes the block busy straight after it is taken
  `PFX_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready,
    "ready straight after a request")

  // a new result is only issued from the busy emit step
  `PFX_ASSERT_NOW(a_emit_busy, $rose(out_valid), $past(!in_ready),
    "result issued while idle")

  // a result never follows an accepted non-space request in the next cycle
  `PFX_ASSERT_NEXT(a_no_quick_result,
    in_valid && in_ready && in_character != pfx_pkg::CH_SPACE,
    !$rose(out_valid), "result too soon after a request")

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_character (in_character),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .out_status   (out_status),
  .out_leftover (out_leftover)
);
